@@ sv/assert_macros.svh @@
// Assertion macros used by the page table walker controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ sv/ptw_pkg.sv @@
// Package: constants, types and helper functions of the page table walker.
`timescale 1ns / 1ps

package ptw_pkg;

	localparam int MEM_WORDS   = 65536;
	localparam int LEVELS      = 4;
	localparam int MEM_AW      = $clog2(MEM_WORDS);
	localparam int LVL_W       = $clog2(LEVELS);
	localparam int VA_W        = 48;
	localparam int PA_W        = 52;
	localparam int DATA_W      = 64;
	localparam int IDX_W       = 9;
	localparam int PG_OFFSET_W = 12;
	localparam int FRAME_W     = PA_W - PG_OFFSET_W;
	localparam int WIDX_W      = PA_W - 3;
	localparam int BIT_PRESENT = 0;
	localparam int BIT_PS      = 7;

	localparam logic [LVL_W-1:0]  LVL_LAST     = LVL_W'(LEVELS - 1);
	localparam logic [WIDX_W-1:0] MEM_WORDS_W  = WIDX_W'(MEM_WORDS);

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_XLATE = 1'b1
	} req_type_t;

	typedef struct packed {
		logic wr_en;   // store the incoming table word
		logic start;   // latch address, read top-level entry
		logic step;    // read next-level entry from current entry frame
		logic finish;  // load the result register
	} ptw_cmd_t;

	typedef struct packed {
		logic oor;
		logic present;
		logic big_page;
		logic last_level;
	} ptw_status_t;

	// Bit position of the index field for a level.
	function automatic int level_shift(input logic [LVL_W-1:0] lvl);
		int s;
		s = PG_OFFSET_W + IDX_W * (LEVELS - 1 - int'(lvl));
		return s;
	endfunction

	// Mask of the offset bits kept from the virtual address.
	function automatic logic [PA_W-1:0] low_mask(input logic [LVL_W-1:0] lvl);
		logic [PA_W-1:0] ones;
		ones = '1;
		return ~(ones << level_shift(lvl));
	endfunction

	function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
			input logic [LVL_W-1:0] lvl);
		logic [PA_W-1:0] va_x;
		va_x = PA_W'(va);
		return IDX_W'(va_x >> level_shift(lvl));
	endfunction

	function automatic logic [1:0] size_code(input logic [LVL_W-1:0] lvl);
		int c;
		c = LEVELS - 1 - int'(lvl);
		if (c > 3) begin
			c = 3;
		end
		return 2'(c);
	endfunction

endpackage

@@ sv/ptw_req_if.sv @@
// Request channel interface: table word writes and translations.
`timescale 1ns / 1ps

interface ptw_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [ptw_pkg::PA_W-1:0]    word_addr;
	logic [ptw_pkg::DATA_W-1:0]  word_data;
	logic [ptw_pkg::VA_W-1:0]    virt_addr;

	modport source (output valid, req_type, word_addr, word_data, virt_addr, input ready);
	modport sink   (input valid, req_type, word_addr, word_data, virt_addr, output ready);
endinterface

@@ sv/ptw_rsp_if.sv @@
// Response channel interface: translation results.
`timescale 1ns / 1ps

interface ptw_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [ptw_pkg::PA_W-1:0] phys_addr;
	logic [1:0]               page_size_code;
	logic                     fault;

	modport source (output valid, phys_addr, page_size_code, fault, input ready);
	modport sink   (input valid, phys_addr, page_size_code, fault, output ready);
endinterface

@@ sv/four_level_page_table_walker.sv @@
// Top level of the four-level page table walker.
// Usage:
//   req channel (valid/ready): req_type 0 writes word_data into the table store at
//   word_addr (word index word_addr>>3; indexes beyond the store are dropped);
//   req_type 1 translates virt_addr and yields one transaction on rsp.
//   cfg_wr_en/cfg_wr_data load the root table address; write it only while idle.
// Sequencing:
//   A write is stored at its accepting edge and leaves the walker idle. A translation
//   issues the top-level read at its accepting edge, then reads one table level per
//   cycle on the single-port table store until a leaf, a fault or the last level; the
//   edge that loads the result register raises rsp.valid and frees req.ready, and no
//   new request is taken while a walk is in progress.
// Reset: arst_n clears the controller, root address and result valid. The table
//   store is not cleared; an entry must be written before a walk reads it.
// Stall: the result register holds while rsp.ready is low, and new requests are
//   still accepted; a walk that finishes with the register still full waits.
`timescale 1ns / 1ps

module four_level_page_table_walker (
	input  logic                      clk,
	input  logic                      arst_n,
	ptw_req_if.sink                   req,
	ptw_rsp_if.source                 rsp,
	input  logic                      cfg_wr_en,
	input  logic [ptw_pkg::PA_W-1:0]  cfg_wr_data
);

	ptw_pkg::ptw_cmd_t    cmd;
	ptw_pkg::ptw_status_t status;

	ptw_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_ready    (req.ready),
		.in_req_type (req.req_type),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.status      (status),
		.cmd         (cmd)
	);

	ptw_datapath u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.in_word_addr       (req.word_addr),
		.in_word_data       (req.word_data),
		.in_virt_addr       (req.virt_addr),
		.cmd                (cmd),
		.status             (status),
		.out_phys_addr      (rsp.phys_addr),
		.out_page_size_code (rsp.page_size_code),
		.out_fault          (rsp.fault)
	);

endmodule

@@ sv/ptw_datapath.sv @@
// Walker datapath: root register, table store, level tracking, result register.
`timescale 1ns / 1ps

module ptw_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ptw_pkg::PA_W-1:0]       cfg_wr_data,
	input  logic [ptw_pkg::PA_W-1:0]       in_word_addr,
	input  logic [ptw_pkg::DATA_W-1:0]     in_word_data,
	input  logic [ptw_pkg::VA_W-1:0]       in_virt_addr,
	input  ptw_pkg::ptw_cmd_t              cmd,
	output ptw_pkg::ptw_status_t           status,
	output logic [ptw_pkg::PA_W-1:0]       out_phys_addr,
	output logic [1:0]                     out_page_size_code,
	output logic                           out_fault
);

	logic [ptw_pkg::DATA_W-1:0]  mem [ptw_pkg::MEM_WORDS];

	logic [ptw_pkg::FRAME_W-1:0] root_q;
	logic [ptw_pkg::VA_W-1:0]    va_q;
	logic [ptw_pkg::LVL_W-1:0]   lvl_q;
	logic [ptw_pkg::DATA_W-1:0]  rdata_q;
	logic                        oor_q;

	logic [ptw_pkg::FRAME_W-1:0] table_cur;
	logic [ptw_pkg::VA_W-1:0]    va_cur;
	logic [ptw_pkg::LVL_W-1:0]   lvl_cur;
	logic [ptw_pkg::WIDX_W-1:0]  widx;
	logic [ptw_pkg::WIDX_W-1:0]  wr_widx;
	logic                        rd_en;
	logic                        fault_now;
	logic [ptw_pkg::PA_W-1:0]    mask;

	assign rd_en     = cmd.start | cmd.step;
	assign table_cur = cmd.start ? root_q : rdata_q[ptw_pkg::PA_W-1:ptw_pkg::PG_OFFSET_W];
	assign va_cur    = cmd.start ? in_virt_addr : va_q;
	assign lvl_cur   = cmd.start ? '0 : ptw_pkg::LVL_W'(lvl_q + 1'b1);
	assign widx      = {table_cur, ptw_pkg::level_index(va_cur, lvl_cur)};
	assign wr_widx   = in_word_addr[ptw_pkg::PA_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
			lvl_q  <= '0;
			oor_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				root_q <= cfg_wr_data[ptw_pkg::PA_W-1:ptw_pkg::PG_OFFSET_W];
			end
			if (rd_en) begin
				lvl_q <= lvl_cur;
				oor_q <= (widx >= ptw_pkg::MEM_WORDS_W);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			va_q <= in_virt_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && (wr_widx < ptw_pkg::MEM_WORDS_W)) begin
			mem[wr_widx[ptw_pkg::MEM_AW-1:0]] <= in_word_data;
		end
		if (rd_en) begin
			rdata_q <= mem[widx[ptw_pkg::MEM_AW-1:0]];
		end
	end

	assign status.oor        = oor_q;
	assign status.present    = rdata_q[ptw_pkg::BIT_PRESENT];
	assign status.big_page   = rdata_q[ptw_pkg::BIT_PS];
	assign status.last_level = (lvl_q == ptw_pkg::LVL_LAST);

	assign fault_now = oor_q | ~rdata_q[ptw_pkg::BIT_PRESENT];
	assign mask      = ptw_pkg::low_mask(lvl_q);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_fault <= fault_now;
			if (fault_now) begin
				out_phys_addr      <= '0;
				out_page_size_code <= '0;
			end else begin
				out_phys_addr      <= (rdata_q[ptw_pkg::PA_W-1:0] & ~mask)
					| (ptw_pkg::PA_W'(va_q) & mask);
				out_page_size_code <= ptw_pkg::size_code(lvl_q);
			end
		end
	end

endmodule

@@ sv/ptw_ctrl.sv @@
// Walker controller: accepts transactions, sequences table reads, owns result valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptw_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_req_type,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  ptw_pkg::ptw_status_t  status,
	output ptw_pkg::ptw_cmd_t     cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_fire;
	logic   walk_done;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = ~out_valid_q | out_ready;
	assign walk_done = status.oor | ~status.present | status.big_page | status.last_level;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.wr_en = in_fire & (in_req_type == ptw_pkg::REQ_WRITE);
				cmd.start = in_fire & (in_req_type == ptw_pkg::REQ_XLATE);
			end
			ST_WALK: begin
				cmd.finish = walk_done & out_free;
				cmd.step   = ~walk_done;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (cmd.finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_IMPLIES(a_finish_room, clk, arst_n, cmd.finish, !out_valid_q || out_ready)
	`ASSERT_NEXT(a_finish_valid, clk, arst_n, cmd.finish, out_valid_q && state_q == ST_IDLE)
	`ASSERT_IMPLIES(a_step_not_last, clk, arst_n, cmd.step, !status.last_level && state_q == ST_WALK)

endmodule

@@ tb/four_level_page_table_walker_test.sv @@
// Self-checking testbench of the four-level page table walker: writes, walks, results.
`timescale 1ns / 1ps

module four_level_page_table_walker_test;

	localparam int PA_W        = ptw_pkg::PA_W;
	localparam int VA_W        = ptw_pkg::VA_W;
	localparam int DATA_W      = ptw_pkg::DATA_W;
	localparam int FRAME_W     = ptw_pkg::FRAME_W;
	localparam int WIDX_W      = ptw_pkg::WIDX_W;
	localparam int IDX_W       = ptw_pkg::IDX_W;
	localparam int LEVELS      = ptw_pkg::LEVELS;
	localparam int MEM_WORDS   = ptw_pkg::MEM_WORDS;
	localparam int PG_OFFSET_W = ptw_pkg::PG_OFFSET_W;
	localparam int BIT_PRESENT = ptw_pkg::BIT_PRESENT;
	localparam int BIT_PS      = ptw_pkg::BIT_PS;

	localparam int          SETTLE_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT   = 300000;
	localparam int          PHASE_ITEMS   = 100;
	localparam int          TOP_SHIFT     = PG_OFFSET_W + IDX_W * (LEVELS - 1);
	localparam logic [PA_W-1:0] FRAME_BITS = {{FRAME_W{1'b1}}, {PG_OFFSET_W{1'b0}}};

	typedef struct packed {
		ptw_pkg::req_type_t kind;
		logic [PA_W-1:0]    addr;
		logic [DATA_W-1:0]  data;
		logic [VA_W-1:0]    va;
	} walk_req_t;

	typedef struct packed {
		logic [PA_W-1:0] pa;
		logic [1:0]      code;
		logic            fault;
	} walk_rsp_t;

	typedef struct packed {
		logic      pinned;
		walk_rsp_t val;
	} pin_t;

	typedef struct packed {
		ptw_pkg::req_type_t kind;
		logic [PA_W-1:0]    addr;
		logic [DATA_W-1:0]  data;
		logic [VA_W-1:0]    va;
		logic               pinned;
		logic [PA_W-1:0]    pa;
		logic [1:0]         code;
		logic               fault;
	} dir_row_t;

	// tables 0..3 at 0x0000..0x3000 form one chain; root stays at its reset value
	dir_row_t dir_rows [24] = '{
		'{ptw_pkg::REQ_WRITE, 52'h0000, 64'h1003, 48'h0, 1'b0, 52'h0, 2'd0, 1'b0},
		'{ptw_pkg::REQ_WRITE, 52'h1000, 64'h2003, 48'h0, 1'b0, 52'h0, 2'd0, 1'b0},
		'{ptw_pkg::REQ_WRITE, 52'h2000, 64'h3003, 48'h0, 1'b0, 52'h0, 2'd0, 1'b0},
		'{ptw_pkg::REQ_WRITE, 52'h3000, 64'h000F_FFFF_FFFF_F003, 48'h0,
			1'b0, 52'h0, 2'd0, 1'b0},
		'{ptw_pkg::REQ_XLATE, 52'h0, 64'h0, 48'h0FFF, 1'b1, 52'hF_FFFF_FFFF_FFFF, 2'd0, 1'b0},
		'{ptw_pkg::REQ_XLATE, 52'h0, 64'h0, 48'h0, 1'b1, 52'hF_FFFF_FFFF_F000, 2'd0, 1'b0},
		'{ptw_pkg::REQ_WRITE, 52'h3008, 64'h0, 48'h0, 1'b0, 52'h0, 2'd0, 1'b0},
		'{ptw_pkg::REQ_XLATE, 52'h0, 64'h0, 48'h1000, 1'b1, 52'h0, 2'd0, 1'b1},
		'{ptw_pkg::REQ_WRITE, 52'h2008, 64'hFFFF_FFFF_FFFF_FFFF, 48'h0,
			1'b0, 52'h0, 2'd0, 1'b0},
		'{ptw_pkg::REQ_XLATE, 52'h0, 64'h0, 48'h3F_FFFF, 1'b1, 52'hF_FFFF_FFFF_FFFF,
			2'd1, 1'b0},
		'{ptw_pkg::REQ_WRITE, 52'h1008, 64'h4000_0000_0000_0081, 48'h0,
			1'b0, 52'h0, 2'd0, 1'b0},
		'{ptw_pkg::REQ_XLATE, 52'h0, 64'h0, 48'h7FFF_FFFF, 1'b1, 52'h3FFF_FFFF, 2'd2, 1'b0},
		'{ptw_pkg::REQ_WRITE, 52'h0FF8, 64'h0000_0080_0000_0081, 48'h0,
			1'b0, 52'h0, 2'd0, 1'b0},
		'{ptw_pkg::REQ_XLATE, 52'h0, 64'h0, 48'hFFFF_FFFF_FFFF, 1'b1, 52'hFF_FFFF_FFFF,
			2'd3, 1'b0},
		'{ptw_pkg::REQ_WRITE, 52'h0010, 64'h8000_0000_0000_0000, 48'h0,
			1'b0, 52'h0, 2'd0, 1'b0},
		'{ptw_pkg::REQ_XLATE, 52'h0, 64'h0, 48'h100_0000_0000, 1'b1, 52'h0, 2'd0, 1'b1},
		'{ptw_pkg::REQ_WRITE, 52'h0018, 64'h000F_FFFF_FFFF_F001, 48'h0,
			1'b0, 52'h0, 2'd0, 1'b0},
		'{ptw_pkg::REQ_XLATE, 52'h0, 64'h0, 48'h180_0000_0000, 1'b1, 52'h0, 2'd0, 1'b1},
		'{ptw_pkg::REQ_WRITE, 52'hF_FFFF_FFFF_FFFF, 64'h0, 48'h0, 1'b0, 52'h0, 2'd0, 1'b0},
		'{ptw_pkg::REQ_WRITE, 52'h8_0000, 64'h0, 48'h0, 1'b0, 52'h0, 2'd0, 1'b0},
		'{ptw_pkg::REQ_WRITE, 52'h8_0000_0000_3000, 64'h0, 48'h0, 1'b0, 52'h0, 2'd0, 1'b0},
		'{ptw_pkg::REQ_WRITE, 52'h3017, 64'h1234_5678_9ABC_D0FF, 48'h0,
			1'b0, 52'h0, 2'd0, 1'b0},
		'{ptw_pkg::REQ_XLATE, 52'h0, 64'h0, 48'h2123, 1'b0, 52'h0, 2'd0, 1'b0},
		'{ptw_pkg::REQ_XLATE, 52'h0, 64'h0, 48'h0, 1'b1, 52'hF_FFFF_FFFF_F000, 2'd0, 1'b0}
	};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [PA_W-1:0]  cfg_wr_data;

	ptw_req_if req_ch ();
	ptw_rsp_if rsp_ch ();

	four_level_page_table_walker dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [DATA_W-1:0] table_words [int];
	logic [PA_W-1:0]   root_copy = '0;
	walk_rsp_t         walk_results_q [$];
	pin_t              pin_q [$];

	// stimulus-side view of the store, used to keep walks on written entries
	logic [DATA_W-1:0] plan_mem [int];
	logic [PA_W-1:0]   plan_root = '0;

	int          src_idle  = 16;
	int          sink_idle = 66;
	int          items_sent = 0;
	int          mismatches = 0;
	int          n_writes = 0;
	int          n_xlates = 0;
	int          n_faults = 0;
	int          n_size [4] = '{0, 0, 0, 0};
	int          n_roots = 1;
	int unsigned cycles = 0;

	function automatic walk_rsp_t walk_tables(input logic [VA_W-1:0] va);
		logic [PA_W-1:0]   tbl;
		logic [PA_W-1:0]   low;
		logic [63:0]       widx;
		logic [DATA_W-1:0] ent;
		walk_rsp_t         r;
		int                sh;
		tbl = root_copy & FRAME_BITS;
		sh = TOP_SHIFT;
		r = '0;
		for (int lvl = 0; lvl < LEVELS; lvl++) begin
			widx = 64'(tbl >> 3) + 64'(va[sh +: IDX_W]);
			if (widx >= 64'(MEM_WORDS)) begin
				r.fault = 1'b1;
				return r;
			end
			ent = table_words.exists(int'(widx)) ? table_words[int'(widx)] : '0;
			if (!ent[BIT_PRESENT]) begin
				r.fault = 1'b1;
				return r;
			end
			if (ent[BIT_PS]) begin
				low = (PA_W'(1) << sh) - PA_W'(1);
				r.pa = (ent[PA_W-1:0] & ~low) | (PA_W'(va) & low);
				r.code = 2'((sh - PG_OFFSET_W) / IDX_W);
				return r;
			end
			tbl = ent[PA_W-1:0] & FRAME_BITS;
			sh -= IDX_W;
		end
		r.pa = tbl | PA_W'(va[PG_OFFSET_W-1:0]);
		return r;
	endfunction

	// random table entry; pointers mostly land on a few low tables so walks share tables
	function automatic logic [DATA_W-1:0] make_entry(input int lvl);
		logic [DATA_W-1:0] e;
		int                r;
		int                f;
		e = {$urandom, $urandom};
		r = $urandom_range(99);
		f = $urandom_range(99);
		if (r < 12) begin
			e[BIT_PRESENT] = 1'b0;
		end else begin
			e[BIT_PRESENT] = 1'b1;
			if (lvl != LEVELS - 1) begin
				if (r < 27) begin
					e[BIT_PS] = 1'b1;
				end else begin
					e[BIT_PS] = 1'b0;
					if (f < 70)
						e[PA_W-1:PG_OFFSET_W] = FRAME_W'($urandom_range(7));
					else if (f < 90)
						e[PA_W-1:PG_OFFSET_W] = FRAME_W'($urandom_range(127));
					else if (f < 95)
						e[PA_W-1:PG_OFFSET_W] = FRAME_W'(128);
					else
						e[PG_OFFSET_W+7] = 1'b1;
				end
			end
		end
		return e;
	endfunction

	task automatic push_item(input walk_req_t it);
		while ($urandom_range(99) < src_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= it.kind;
		req_ch.word_addr <= it.addr;
		req_ch.word_data <= it.data;
		req_ch.virt_addr <= it.va;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic send_write(input logic [PA_W-1:0] addr, input logic [DATA_W-1:0] data);
		logic [63:0] widx;
		widx = 64'(addr >> 3);
		if (widx < 64'(MEM_WORDS)) begin
			plan_mem[int'(widx)] = data;
		end
		items_sent++;
		push_item('{kind: ptw_pkg::REQ_WRITE, addr: addr, data: data,
			va: VA_W'({$urandom, $urandom})});
	endtask

	task automatic send_xlate(input logic [VA_W-1:0] va, input logic pinned,
			input walk_rsp_t val);
		pin_q.push_back('{pinned: pinned, val: val});
		items_sent++;
		push_item('{kind: ptw_pkg::REQ_XLATE, addr: PA_W'({$urandom, $urandom}),
			data: {$urandom, $urandom}, va: va});
	endtask

	// fill in every entry the walk will read before translating
	task automatic random_walk();
		logic [VA_W-1:0]   va;
		logic [PA_W-1:0]   tbl;
		logic [63:0]       widx;
		logic [DATA_W-1:0] ent;
		int                sh;
		va = VA_W'({$urandom, $urandom});
		for (int lvl = 0; lvl < LEVELS; lvl++) begin
			if ($urandom_range(1))
				va[PG_OFFSET_W + IDX_W * (LEVELS - 1 - lvl) +: IDX_W] =
					IDX_W'($urandom_range(3));
		end
		tbl = plan_root & FRAME_BITS;
		sh = TOP_SHIFT;
		for (int lvl = 0; lvl < LEVELS; lvl++) begin
			widx = 64'(tbl >> 3) + 64'(va[sh +: IDX_W]);
			if (widx >= 64'(MEM_WORDS))
				break;
			if (!plan_mem.exists(int'(widx)))
				send_write({widx[WIDX_W-1:0], 3'($urandom)}, make_entry(lvl));
			ent = plan_mem[int'(widx)];
			if (!ent[BIT_PRESENT] || ent[BIT_PS])
				break;
			tbl = ent[PA_W-1:0] & FRAME_BITS;
			sh -= IDX_W;
		end
		send_xlate(va, 1'b0, '0);
	endtask

	// hold off the sender until every translation has answered
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (walk_results_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_root(input logic [PA_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		plan_root = v;
		n_roots++;
	endtask

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= sink_idle);
	end

	always @(posedge clk) begin : monitor
		logic [63:0] widx;
		walk_rsp_t   want;
		pin_t        pin;
		if (cfg_wr_en)
			root_copy = cfg_wr_data;
		if (req_ch.valid && req_ch.ready) begin
			if (req_ch.req_type == ptw_pkg::REQ_WRITE) begin
				n_writes++;
				widx = 64'(req_ch.word_addr >> 3);
				if (widx < 64'(MEM_WORDS))
					table_words[int'(widx)] = req_ch.word_data;
			end else begin
				n_xlates++;
				pin = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
				want = pin.pinned ? pin.val : walk_tables(req_ch.virt_addr);
				walk_results_q.push_back(want);
			end
		end
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (rsp_ch.fault)
				n_faults++;
			else
				n_size[rsp_ch.page_size_code]++;
			if (walk_results_q.size() == 0) begin
				$error("unexpected result transaction: phys_addr %h fault %b",
					rsp_ch.phys_addr, rsp_ch.fault);
				mismatches++;
			end else begin
				want = walk_results_q.pop_front();
				if (rsp_ch.phys_addr !== want.pa) begin
					$error("phys_addr: expected %h, got %h", want.pa, rsp_ch.phys_addr);
					mismatches++;
				end
				if (rsp_ch.page_size_code !== want.code) begin
					$error("page_size_code: expected %0d, got %0d", want.code,
						rsp_ch.page_size_code);
					mismatches++;
				end
				if (rsp_ch.fault !== want.fault) begin
					$error("fault: expected %b, got %b", want.fault, rsp_ch.fault);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				walk_results_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int               r;
		logic [PA_W-1:0]  addr;
		logic [PA_W-1:0]  root;
		int               start;
		arst_n            = 1'b0;
		cfg_wr_en        <= 1'b0;
		cfg_wr_data      <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.req_type  <= ptw_pkg::REQ_WRITE;
		req_ch.word_addr <= '0;
		req_ch.word_data <= '0;
		req_ch.virt_addr <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ptw_pkg::REQ_WRITE)
				send_write(dir_rows[i].addr, dir_rows[i].data);
			else
				send_xlate(dir_rows[i].va, dir_rows[i].pinned,
					'{pa: dir_rows[i].pa, code: dir_rows[i].code, fault: dir_rows[i].fault});
		end

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			src_idle  = (ph < 2) ? 16 : (ph < 4) ? 66 : 0;
			sink_idle = (ph < 2) ? 66 : (ph < 4) ? 16 : 0;
			case (ph)
				0: root = (PA_W'($urandom_range(7)) << PG_OFFSET_W)
					| PA_W'($urandom_range(4095));
				1: root = '0;
				2: root = (PA_W'($urandom_range(127)) << PG_OFFSET_W)
					| PA_W'($urandom_range(4095));
				3: root = '1;
				4: root = PA_W'(52'h7_FFFF);
				default: root = PA_W'($urandom_range(7)) << PG_OFFSET_W;
			endcase
			set_root(root);
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 85) begin
					random_walk();
				end else if (r < 95) begin
					addr = PA_W'($urandom_range(1) ? $urandom_range(4095)
						: $urandom_range(MEM_WORDS - 1)) << 3;
					send_write(addr | PA_W'($urandom_range(7)),
						make_entry($urandom_range(LEVELS - 1)));
				end else begin
					addr = PA_W'({$urandom, $urandom});
					addr[19 + $urandom_range(PA_W - 20)] = 1'b1;
					send_write(addr, {$urandom, $urandom});
				end
			end
		end

		drain();
		$display("Run covered %0d table word writes and %0d translations under %0d root settings.",
			n_writes, n_xlates, n_roots);
		$display("Walk outcomes: %0d faults, pages of 4K %0d, 2M %0d, 1G %0d, 512G %0d.",
			n_faults, n_size[0], n_size[1], n_size[2], n_size[3]);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
